// ===== sv/tpg_pkg.sv =====
package tpg_pkg;

	localparam int MAX_SIDE_DEF  = 4096;
	localparam int GRAY_BITS_DEF = 16;

	// Gradient quotient bits; one divider stage per bit.
	localparam int Q_STEPS = 16;
	localparam int NUM_W   = 29;
	localparam int DEN_W   = 14;

	typedef enum logic [2:0] {
		MODE_CHECKS,
		MODE_STRIPES,
		MODE_XGRAD,
		MODE_XYGRAD,
		MODE_DISK,
		MODE_ROSETTE,
		MODE_SQUARE,
		MODE_RECT
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_SIDE,
		REG_FMIN,
		REG_FMAX,
		REG_SQSIDE,
		REG_GMIN,
		REG_GMAX
	} cfg_reg_t;

	// True when d lies in the centered span [-(n/2), n-1-n/2].
	function automatic logic in_span(input logic signed [13:0] d, input logic [12:0] n);
		logic signed [14:0] lo;
		logic signed [14:0] hi;
		logic signed [14:0] dx;
		lo = -$signed({3'b000, n[12:1]});
		hi = $signed({2'b00, n}) - 15'sd1 - $signed({3'b000, n[12:1]});
		dx = {d[13], d};
		return (dx >= lo) && (dx <= hi);
	endfunction

endpackage

// ===== sv/tpg_coord_if.sv =====
interface tpg_coord_if;
	logic        valid;
	logic        ready;
	logic [11:0] row;
	logic [11:0] col;

	modport source (output valid, output row, output col, input ready);
	modport sink (input valid, input row, input col, output ready);
endinterface

// ===== sv/tpg_pixel_if.sv =====
interface tpg_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

// ===== sv/tpg_div.sv =====
module tpg_div import tpg_pkg::*; #(
	parameter int NW = NUM_W,
	parameter int DW = DEN_W,
	parameter int QW = Q_STEPS
) (
	input  logic          clk,
	input  logic [QW-1:0] en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] q
);

	// Restoring division, one quotient bit per stage. The caller keeps
	// num below den * 2**QW, so the top bits start as a valid remainder.
	// The caller must hold den static while beats are in flight; the divider does not enforce it.
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [DW-1:0] r_in;
		logic [QW-1:0] l_in;
		logic [QW-1:0] q_in;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_head
			assign r_in = DW'(num[NW-1:QW]);
			assign l_in = num[QW-1:0];
			assign q_in = '0;
		end else begin : g_body
			assign r_in = rem_s[k-1];
			assign l_in = low_s[k-1];
			assign q_in = quo_s[k-1];
		end

		always_comb begin
			t  = {r_in, l_in[QW-1]};
			ge = t >= {1'b0, den};
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= ge ? DW'(t - {1'b0, den}) : DW'(t);
				low_s[k] <= {l_in[QW-2:0], 1'b0};
				quo_s[k] <= {q_in[QW-2:0], ge};
			end
		end
	end

	assign q = quo_s[QW-1];

endmodule

// ===== sv/test_pattern_pixel_generator_top.sv =====
// Data passes the input register, the operand stage, the divider stages and the output register.
// Throughput: one pixel per clock while the output is ready; the 16-stage restoring dividers set the depth.
// Stages stall independently, so bubbles close up while the output waits.
// Reset (arst_n low) empties the pipeline and loads the register defaults:
// checks, side 64, features 8/8, square 5, grays 0 and 255.
module test_pattern_pixel_generator_top import tpg_pkg::*; #(
	parameter int MAX_SIDE  = MAX_SIDE_DEF,
	parameter int GRAY_BITS = GRAY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [15:0]   cfg_data,
	tpg_coord_if.sink     in_ch,
	tpg_pixel_if.source   out_ch
);

	localparam int LAST = Q_STEPS + 2;
	localparam logic [16:0] GLIM = 17'((1 << GRAY_BITS) - 1);
	localparam logic [16:0] SMAX = 17'(MAX_SIDE);

	mode_t       mode_q;
	logic [12:0] side_q, fmin_q, fmax_q, sqs_q;
	logic [15:0] gmin_q, gmax_q;
	logic [25:0] fsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CHECKS;
			side_q <= 13'd64;
			fmin_q <= 13'd8;
			fmax_q <= 13'd8;
			sqs_q  <= 13'd5;
			gmin_q <= 16'd0;
			gmax_q <= 16'd255;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MODE:   mode_q <= mode_t'(cfg_data[2:0]);
				REG_SIDE:   side_q <= cfg_data[12:0];
				REG_FMIN:   fmin_q <= cfg_data[12:0];
				REG_FMAX:   fmax_q <= cfg_data[12:0];
				REG_SQSIDE: sqs_q  <= cfg_data[12:0];
				REG_GMIN:   gmin_q <= cfg_data;
				REG_GMAX:   gmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Used only in the disk compare.
	always_ff @(posedge clk) begin
		fsq_q <= fmax_q * fmax_q;
	end

	logic [12:0] side_c, half_c, per_c;
	logic [15:0] fg_c;
	logic        inv_c;
	logic [13:0] den_c;

	always_comb begin
		if (side_q < 13'd2) begin
			side_c = 13'd2;
		end else if ({4'b0000, side_q} > SMAX) begin
			side_c = SMAX[12:0];
		end else begin
			side_c = side_q;
		end
		half_c = {1'b0, side_c[12:1]};
		per_c  = (fmax_q == '0) ? 13'd1 : fmax_q;
		fg_c   = ({1'b0, gmax_q} > GLIM) ? GLIM[15:0] : gmax_q;
		inv_c  = fg_c < gmin_q;
		if (mode_q == MODE_XYGRAD) begin
			den_c = {side_c, 1'b0} - 14'd2;
		end else begin
			den_c = {1'b0, side_c} - 14'd1;
		end
	end

	// Stall chain: a stage moves when it is empty or its successor moves.
	logic [LAST:0] vld_q;
	logic [LAST:0] adv;

	always_comb begin
		adv[LAST] = !vld_q[LAST] || out_ch.ready;
		for (int k = LAST - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_ch.valid;
			end
			for (int k = 1; k <= LAST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ch.ready = adv[0];

	logic [11:0] row_s1, col_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			row_s1 <= in_ch.row;
			col_s1 <= in_ch.col;
		end
	end

	logic signed [13:0] dy, dx;
	logic [11:0]        ady, adx;
	logic [12:0]        pos;
	logic               shape_c;

	always_comb begin
		dy  = $signed({2'b00, row_s1}) - $signed({1'b0, half_c});
		dx  = $signed({2'b00, col_s1}) - $signed({1'b0, half_c});
		ady = dy[13] ? 12'(-dy) : dy[11:0];
		adx = dx[13] ? 12'(-dx) : dx[11:0];
		pos = (mode_q == MODE_XYGRAD) ? ({1'b0, row_s1} + {1'b0, col_s1}) : {1'b0, col_s1};
		case (mode_q)
			MODE_ROSETTE: shape_c = !dy[13] && (dy <= 14'sd2) && !dx[13] && (dx <= 14'sd2)
					&& (dy[0] == dx[0]);
			MODE_SQUARE:  shape_c = in_span(dy, sqs_q) && in_span(dx, sqs_q)
					&& ({1'b0, ady} <= fmax_q[12:1]) && ({1'b0, adx} <= fmax_q[12:1]);
			MODE_RECT:    shape_c = in_span(dy, fmax_q) && in_span(dx, fmin_q);
			default:      shape_c = in_span(dy, fmax_q) && in_span(dx, fmax_q);
		endcase
	end

	logic [11:0]       row_s2, col_s2;
	logic [NUM_W-1:0]  prod_s2;
	logic [23:0]       sy_s2, sx_s2;
	logic              shape_s2, out_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			prod_s2  <= inv_c ? '0 : (fg_c - gmin_q) * pos;
			sy_s2    <= ady * ady;
			sx_s2    <= adx * adx;
			shape_s2 <= shape_c;
			out_s2   <= (row_s1 >= side_c[11:0] && side_c[12] == 1'b0)
					|| (col_s1 >= side_c[11:0] && side_c[12] == 1'b0);
		end
	end

	// Side band beside the dividers: {outside, lit}.
	logic [1:0] sb_s [2:LAST-1];
	logic       lit_c;

	assign lit_c = (mode_q == MODE_DISK)
			? (shape_s2 && ({1'b0, sy_s2} + {1'b0, sx_s2}) <= 25'(fsq_q >> 2)
				&& ({sy_s2 + sx_s2 + 24'd0, 2'b00} <= {1'b0, fsq_q}))
			: shape_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sb_s[2] <= {out_s2, lit_c};
		end
		for (int k = 3; k < LAST; k++) begin
			if (adv[k]) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	logic [Q_STEPS-1:0] qr, qc, qg;

	tpg_div u_div_row (
		.clk (clk),
		.en  (adv[LAST-1:2]),
		.num (NUM_W'(row_s2)),
		.den ({1'b0, per_c}),
		.q   (qr)
	);

	tpg_div u_div_col (
		.clk (clk),
		.en  (adv[LAST-1:2]),
		.num (NUM_W'(col_s2)),
		.den ({1'b0, per_c}),
		.q   (qc)
	);

	tpg_div u_div_ramp (
		.clk (clk),
		.en  (adv[LAST-1:2]),
		.num (prod_s2),
		.den (den_c),
		.q   (qg)
	);

	logic [15:0] pix_c;
	logic [15:0] pix_s19;

	always_comb begin
		if (sb_s[LAST-1][1]) begin
			pix_c = gmin_q;
		end else begin
			case (mode_q)
				MODE_CHECKS:  pix_c = (qr[0] ^ qc[0]) ? gmin_q : fg_c;
				MODE_STRIPES: pix_c = qc[0] ? fg_c : gmin_q;
				MODE_XGRAD,
				MODE_XYGRAD:  pix_c = inv_c ? gmin_q : gmin_q + qg;
				default:      pix_c = sb_s[LAST-1][0] ? fg_c : gmin_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv[LAST]) begin
			pix_s19 <= pix_c;
		end
	end

	assign out_ch.valid       = vld_q[LAST];
	assign out_ch.pixel_value = pix_s19;

	// With the output stage empty the whole stall chain is open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input stalled with empty output stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_q[0])
		else $error("accepted beat missing from first stage");

	a_two_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (mode_q == MODE_CHECKS || mode_q == MODE_STRIPES
			|| mode_q == MODE_DISK || mode_q == MODE_ROSETTE
			|| mode_q == MODE_SQUARE || mode_q == MODE_RECT)
		|-> (out_ch.pixel_value == gmin_q || out_ch.pixel_value == fg_c))
		else $error("two-level pattern gave a third gray");

endmodule
